FILE: hdl/mlr_pkg.sv
// shared octant codes, octant flags and octant helper functions
package mlr_pkg;

  typedef logic [2:0] octant_t;

  // octant codes, y grows downward
  localparam octant_t OCT_0 = 3'd0;
  localparam octant_t OCT_1 = 3'd1;
  localparam octant_t OCT_2 = 3'd2;
  localparam octant_t OCT_3 = 3'd3;
  localparam octant_t OCT_4 = 3'd4;
  localparam octant_t OCT_5 = 3'd5;
  localparam octant_t OCT_6 = 3'd6;
  localparam octant_t OCT_7 = 3'd7;

  // how a folded (major, minor) offset maps back to screen axes
  typedef struct packed {
    logic swap;   // major runs along y
    logic neg_x;  // x offset is negated
    logic neg_y;  // y offset is negated
  } oct_flags_t;

  function automatic octant_t find_octant(input logic neg_x, input logic neg_y,
                                          input logic flat);
    octant_t oct;
    case ({neg_x, neg_y})
      2'b00:   oct = flat ? OCT_0 : OCT_7;
      2'b01:   oct = flat ? OCT_1 : OCT_2;
      2'b10:   oct = flat ? OCT_5 : OCT_6;
      default: oct = flat ? OCT_4 : OCT_3;
    endcase
    return oct;
  endfunction

  function automatic oct_flags_t octant_flags(input octant_t oct);
    oct_flags_t f;
    case (oct)
      OCT_0:   f = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
      OCT_1:   f = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b1};
      OCT_2:   f = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b1};
      OCT_3:   f = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b1};
      OCT_4:   f = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b1};
      OCT_5:   f = '{swap: 1'b0, neg_x: 1'b1, neg_y: 1'b0};
      OCT_6:   f = '{swap: 1'b1, neg_x: 1'b1, neg_y: 1'b0};
      OCT_7:   f = '{swap: 1'b1, neg_x: 1'b0, neg_y: 1'b0};
      default: f = '{swap: 1'b0, neg_x: 1'b0, neg_y: 1'b0};
    endcase
    return f;
  endfunction

endpackage

FILE: hdl/mlr_in_if.sv
// command channel: start or step items
interface mlr_in_if #(parameter int COORD_BITS = 11) ();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [COORD_BITS-1:0] start_x;
  logic [COORD_BITS-1:0] start_y;
  logic [COORD_BITS-1:0] end_x;
  logic [COORD_BITS-1:0] end_y;
  logic [31:0]           colour;

  modport source (output valid, mode, start_x, start_y, end_x, end_y, colour,
                  input ready);
  modport sink (input valid, mode, start_x, start_y, end_x, end_y, colour,
                output ready);
endinterface

FILE: hdl/mlr_out_if.sv
// pixel channel: one result per command
interface mlr_out_if #(parameter int COORD_BITS = 11) ();
  logic                  valid;
  logic                  ready;
  logic                  valid_res;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [31:0]           pixel_colour;
  logic                  last;

  modport source (output valid, valid_res, pixel_x, pixel_y, pixel_colour, last,
                  input ready);
  modport sink (input valid, valid_res, pixel_x, pixel_y, pixel_colour, last,
                output ready);
endinterface

FILE: hdl/mlr_setup.sv
// line setup: octant and fold of the end point offset into octant 0
module mlr_setup import mlr_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output octant_t               octant,
  output logic [COORD_BITS-1:0] major,
  output logic [COORD_BITS-1:0] minor
);

  logic [COORD_BITS:0]   dx;
  logic [COORD_BITS:0]   dy;
  logic [COORD_BITS:0]   dx_abs;
  logic [COORD_BITS:0]   dy_abs;
  logic [COORD_BITS-1:0] ax;
  logic [COORD_BITS-1:0] ay;
  logic                  flat;

  always_comb begin
    dx     = {1'b0, end_x} - {1'b0, start_x};
    dy     = {1'b0, end_y} - {1'b0, start_y};
    dx_abs = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
    dy_abs = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
    ax     = dx_abs[COORD_BITS-1:0];
    ay     = dy_abs[COORD_BITS-1:0];
    flat   = (ax >= ay);
    octant = find_octant(dx[COORD_BITS], dy[COORD_BITS], flat);
    major  = flat ? ax : ay;
    minor  = flat ? ay : ax;
  end

endmodule

FILE: hdl/mlr_walker.sv
// line state, midpoint decision step and unfold back to screen coordinates
module mlr_walker import mlr_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  mode,
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [31:0]           colour,
  input  octant_t               setup_octant,
  input  logic [COORD_BITS-1:0] setup_major,
  input  logic [COORD_BITS-1:0] setup_minor,
  output logic                  res_valid_res,
  output logic [COORD_BITS-1:0] res_pixel_x,
  output logic [COORD_BITS-1:0] res_pixel_y,
  output logic [31:0]           res_pixel_colour,
  output logic                  res_last,
  output logic                  line_active
);

  localparam int DEC_BITS = COORD_BITS + 3;

  octant_t               octant_code;
  logic [COORD_BITS-1:0] origin_x;
  logic [COORD_BITS-1:0] origin_y;
  logic [COORD_BITS-1:0] major_length;
  logic [COORD_BITS-1:0] minor_length;
  logic [COORD_BITS-1:0] step_major;
  logic [COORD_BITS-1:0] step_minor;
  logic [DEC_BITS-1:0]   decision;
  logic [31:0]           line_colour;

  logic [COORD_BITS-1:0] step_major_next;
  logic [COORD_BITS-1:0] step_minor_next;
  logic [DEC_BITS-1:0]   decision_next;
  logic [DEC_BITS-1:0]   decision_init;
  logic [COORD_BITS-1:0] gap;
  logic                  step_last;
  oct_flags_t            flags;
  logic [COORD_BITS-1:0] off_u;
  logic [COORD_BITS-1:0] off_v;
  logic [COORD_BITS-1:0] off_x;
  logic [COORD_BITS-1:0] off_y;

  always_comb begin
    gap           = major_length - minor_length;
    decision_init = {3'b000, setup_major} - {2'b00, setup_minor, 1'b0};
    // negative decision: minor coordinate advances
    if (decision[DEC_BITS-1]) begin
      step_minor_next = step_minor + 1'b1;
      decision_next   = decision + {2'b00, gap, 1'b0};
    end else begin
      step_minor_next = step_minor;
      decision_next   = decision - {2'b00, minor_length, 1'b0};
    end
    step_major_next = step_major + 1'b1;
    step_last       = (step_major_next >= major_length);

    // start pixel has zero offset, so the stored octant serves either way
    flags = octant_flags(octant_code);
    off_u = mode ? step_major_next : '0;
    off_v = mode ? step_minor_next : '0;
    off_x = flags.swap ? off_v : off_u;
    off_y = flags.swap ? off_u : off_v;
    if (flags.neg_x) off_x = ~off_x + 1'b1;
    if (flags.neg_y) off_y = ~off_y + 1'b1;

    if (!mode) begin
      res_valid_res    = 1'b1;
      res_pixel_x      = start_x;
      res_pixel_y      = start_y;
      res_pixel_colour = colour;
      res_last         = (setup_major == '0);
    end else if (line_active) begin
      res_valid_res    = 1'b1;
      res_pixel_x      = origin_x + off_x;
      res_pixel_y      = origin_y + off_y;
      res_pixel_colour = line_colour;
      res_last         = step_last;
    end else begin
      res_valid_res    = 1'b0;
      res_pixel_x      = '0;
      res_pixel_y      = '0;
      res_pixel_colour = '0;
      res_last         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (advance) begin
      if (!mode) begin
        line_active <= (setup_major != '0);
      end else if (line_active) begin
        line_active <= !step_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (!mode) begin
        octant_code  <= setup_octant;
        origin_x     <= start_x;
        origin_y     <= start_y;
        major_length <= setup_major;
        minor_length <= setup_minor;
        step_major   <= '0;
        step_minor   <= '0;
        decision     <= decision_init;
        line_colour  <= colour;
      end else if (line_active) begin
        step_major <= step_major_next;
        step_minor <= step_minor_next;
        decision   <= decision_next;
      end
    end
  end

endmodule

FILE: hdl/midpoint_line_rasterizer.sv
// midpoint line rasterizer top level: command register, line walker, pixel register
//
//  channel | role   | transfer moves
//  --------+--------+-----------------------------------------------------------
//  cmd     | sink   | mode, start_x, start_y, end_x, end_y, colour
//  pix     | source | valid_res, pixel_x, pixel_y, pixel_colour, last
//
// one command per cycle sustained while pix is not stalled, one pixel result for every command
// a command sits in the command register until it advances, then its pixel moves
// to the pixel register, whose full flag drives pix valid
// the rate is set by the decision add/compare and the octant unfold mux
// rst (synchronous) clears both register valids and the active-line flag
// a stalled pix holds its register; cmd stays ready while the queue can move
module midpoint_line_rasterizer import mlr_pkg::*; #(
  parameter int COORD_BITS = 11
) (
  input  logic      clk,
  input  logic      rst,
  mlr_in_if.sink    cmd,
  mlr_out_if.source pix
);

  // command register
  logic                  cmd_full;
  logic                  cmd_mode;
  logic [COORD_BITS-1:0] cmd_start_x;
  logic [COORD_BITS-1:0] cmd_start_y;
  logic [COORD_BITS-1:0] cmd_end_x;
  logic [COORD_BITS-1:0] cmd_end_y;
  logic [31:0]           cmd_colour;

  // pixel register
  logic                  pix_full;
  logic                  pix_valid_res;
  logic [COORD_BITS-1:0] pix_x;
  logic [COORD_BITS-1:0] pix_y;
  logic [31:0]           pix_colour;
  logic                  pix_last;

  // setup results for the held command
  octant_t               setup_octant;
  logic [COORD_BITS-1:0] setup_major;
  logic [COORD_BITS-1:0] setup_minor;

  // walker results for the held command
  logic                  res_valid_res;
  logic [COORD_BITS-1:0] res_pixel_x;
  logic [COORD_BITS-1:0] res_pixel_y;
  logic [31:0]           res_pixel_colour;
  logic                  res_last;
  logic                  line_active;

  logic advance;
  logic cmd_take;

  // the held command moves on when the pixel register is free or drains now
  assign advance  = cmd_full && (!pix_full || pix.ready);
  assign cmd.ready = !cmd_full || advance;
  assign cmd_take = cmd.valid && cmd.ready;

  assign pix.valid        = pix_full;
  assign pix.valid_res    = pix_valid_res;
  assign pix.pixel_x      = pix_x;
  assign pix.pixel_y      = pix_y;
  assign pix.pixel_colour = pix_colour;
  assign pix.last         = pix_last;

  mlr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
    .start_x (cmd_start_x),
    .start_y (cmd_start_y),
    .end_x   (cmd_end_x),
    .end_y   (cmd_end_y),
    .octant  (setup_octant),
    .major   (setup_major),
    .minor   (setup_minor)
  );

  mlr_walker #(.COORD_BITS(COORD_BITS)) u_walker (
    .clk              (clk),
    .rst              (rst),
    .advance          (advance),
    .mode             (cmd_mode),
    .start_x          (cmd_start_x),
    .start_y          (cmd_start_y),
    .colour           (cmd_colour),
    .setup_octant     (setup_octant),
    .setup_major      (setup_major),
    .setup_minor      (setup_minor),
    .res_valid_res    (res_valid_res),
    .res_pixel_x      (res_pixel_x),
    .res_pixel_y      (res_pixel_y),
    .res_pixel_colour (res_pixel_colour),
    .res_last         (res_last),
    .line_active      (line_active)
  );

  // valid flags of both registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_full <= 1'b0;
      pix_full <= 1'b0;
    end else begin
      if (cmd_take) begin
        cmd_full <= 1'b1;
      end else if (advance) begin
        cmd_full <= 1'b0;
      end
      if (advance) begin
        pix_full <= 1'b1;
      end else if (pix.ready) begin
        pix_full <= 1'b0;
      end
    end
  end

  // payloads, no reset needed
  always_ff @(posedge clk) begin
    if (cmd_take) begin
      cmd_mode    <= cmd.mode;
      cmd_start_x <= cmd.start_x;
      cmd_start_y <= cmd.start_y;
      cmd_end_x   <= cmd.end_x;
      cmd_end_y   <= cmd.end_y;
      cmd_colour  <= cmd.colour;
    end
    if (advance) begin
      pix_valid_res <= res_valid_res;
      pix_x         <= res_pixel_x;
      pix_y         <= res_pixel_y;
      pix_colour    <= res_pixel_colour;
      pix_last      <= res_last;
    end
  end

`ifndef NO_ASSERTIONS
  // a start command always yields a real pixel
  a_start_gives_pixel: assert property (@(posedge clk) disable iff (rst)
    advance && !cmd_mode |=> pix_full && pix_valid_res)
    else $error("start command did not give a pixel");

  // a step with no active line yields an empty result
  a_idle_step_empty: assert property (@(posedge clk) disable iff (rst)
    advance && cmd_mode && !line_active |=> pix_full && !pix_valid_res)
    else $error("step without line gave a pixel");

  // the last pixel ends the line
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    advance && res_last |=> !line_active)
    else $error("line still active after last pixel");

  // a command is only taken into a full register when the old one moves on
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd_take && cmd_full |-> advance)
    else $error("command register overwritten");

  // a stalled pixel is not replaced
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_full && !pix.ready |-> !advance)
    else $error("pixel register replaced while stalled");
`endif

endmodule

FILE: sim/tb_midpoint_line_rasterizer.sv
// testbench for the midpoint line rasterizer: queued commands, line walk prediction, pixel checks
`timescale 1ns / 100ps

module tb_midpoint_line_rasterizer import mlr_pkg::*; ();

  localparam int CW          = 11;        // coordinate width of this build
  localparam int MAX_COORD   = (1 << CW) - 1;
  localparam int HOLD_CYCLES = 300;       // long pixel-side hold-off
  localparam int TAIL_CYCLES = 8;         // margin for stray pixels after the drain
  localparam int LIMIT       = 400000;    // generous cycle budget for the whole run

  // command modes
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

  typedef struct {
    logic          mode;
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    logic [CW-1:0] ex;
    logic [CW-1:0] ey;
    logic [31:0]   colour;
  } line_cmd_t;

  typedef struct {
    logic          valid_res;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [31:0]   colour;
    logic          last;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  mlr_in_if  #(.COORD_BITS(CW)) cmd_bus ();
  mlr_out_if #(.COORD_BITS(CW)) pix_bus ();

  midpoint_line_rasterizer #(.COORD_BITS(CW)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_bus),
    .pix (pix_bus)
  );

  // commands waiting for the driver, pixels waiting for the monitor
  line_cmd_t pending_cmds[$];
  pixel_t    expected_pixels[$];

  // idling knobs, changed only between phases (on the falling edge), and hold-off state
  int src_idle_pct  = 0;
  int snk_stall_pct = 0;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;

  int errors       = 0;
  int cycle_count  = 0;
  int n_starts     = 0;
  int n_steps      = 0;
  int n_pixels     = 0;
  int n_empty      = 0;

  // predictor copy of the line walker state
  logic                 ln_active;
  octant_t              ln_oct;
  logic [CW-1:0]        org_x;
  logic [CW-1:0]        org_y;
  logic signed [CW+1:0] major_len;
  logic signed [CW+1:0] minor_len;
  logic signed [CW+1:0] walk_major;
  logic signed [CW+1:0] walk_minor;
  logic signed [CW+3:0] dec;
  logic [31:0]          ln_colour;

  // map the folded walk position back to screen space and add the origin
  function automatic pixel_t place_pixel(input logic is_last);
    logic signed [CW+1:0] ox;
    logic signed [CW+1:0] oy;
    pixel_t p;
    case (ln_oct)
      OCT_0:   begin ox =  walk_major; oy =  walk_minor; end
      OCT_1:   begin ox =  walk_major; oy = -walk_minor; end
      OCT_2:   begin ox =  walk_minor; oy = -walk_major; end
      OCT_3:   begin ox = -walk_minor; oy = -walk_major; end
      OCT_4:   begin ox = -walk_major; oy = -walk_minor; end
      OCT_5:   begin ox = -walk_major; oy =  walk_minor; end
      OCT_6:   begin ox = -walk_minor; oy =  walk_major; end
      default: begin ox =  walk_minor; oy =  walk_major; end
    endcase
    p.valid_res = 1'b1;
    p.x         = org_x + ox[CW-1:0];   // wraps modulo the coordinate range
    p.y         = org_y + oy[CW-1:0];
    p.colour    = ln_colour;
    p.last      = is_last;
    return p;
  endfunction

  // advance the predicted walker by one command and give the pixel it yields
  function automatic pixel_t rasterize(input line_cmd_t c);
    logic signed [CW+1:0] dx;
    logic signed [CW+1:0] dy;
    logic signed [CW+1:0] adx;
    logic signed [CW+1:0] ady;
    logic                 flat;
    pixel_t               p;
    p = '{default: '0};
    if (c.mode == MODE_START) begin
      dx   = $signed({2'b00, c.ex}) - $signed({2'b00, c.sx});
      dy   = $signed({2'b00, c.ey}) - $signed({2'b00, c.sy});
      adx  = (dx < 0) ? -dx : dx;
      ady  = (dy < 0) ? -dy : dy;
      flat = (adx >= ady);
      // octant from the signs of the offset, y pointing down
      if (dx >= 0) begin
        if (dy >= 0) ln_oct = flat ? OCT_0 : OCT_7;
        else         ln_oct = flat ? OCT_1 : OCT_2;
      end else begin
        if (dy >= 0) ln_oct = flat ? OCT_5 : OCT_6;
        else         ln_oct = flat ? OCT_4 : OCT_3;
      end
      // fold the offset into octant 0: major >= minor >= 0
      case (ln_oct)
        OCT_0:   begin major_len =  dx; minor_len =  dy; end
        OCT_1:   begin major_len =  dx; minor_len = -dy; end
        OCT_2:   begin major_len = -dy; minor_len =  dx; end
        OCT_3:   begin major_len = -dy; minor_len = -dx; end
        OCT_4:   begin major_len = -dx; minor_len = -dy; end
        OCT_5:   begin major_len = -dx; minor_len =  dy; end
        OCT_6:   begin major_len =  dy; minor_len = -dx; end
        default: begin major_len =  dy; minor_len =  dx; end
      endcase
      org_x      = c.sx;
      org_y      = c.sy;
      walk_major = '0;
      walk_minor = '0;
      dec        = major_len - 2 * minor_len;
      ln_colour  = c.colour;
      // coincident end points give one pixel and no active line
      ln_active  = (major_len != 0);
      p          = place_pixel(major_len == 0);
    end else if (ln_active) begin
      // doubled midpoint decision, a tie keeps the minor coordinate
      if (dec < 0) begin
        walk_minor = walk_minor + 1;
        dec        = dec + 2 * (major_len - minor_len);
      end else begin
        dec        = dec - 2 * minor_len;
      end
      walk_major = walk_major + 1;
      if (walk_major >= major_len) ln_active = 1'b0;
      p = place_pixel(walk_major >= major_len);
    end
    return p;
  endfunction

  task automatic push_cmd(input logic mode, input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                          input logic [CW-1:0] ex, input logic [CW-1:0] ey,
                          input logic [31:0] colour);
    line_cmd_t c;
    c = '{mode: mode, sx: sx, sy: sy, ex: ex, ey: ey, colour: colour};
    pending_cmds.push_back(c);
  endtask

  // step commands carry random junk in the fields the block should ignore
  task automatic push_random_step();
    push_cmd(MODE_STEP, CW'($urandom_range(MAX_COORD)), CW'($urandom_range(MAX_COORD)),
             CW'($urandom_range(MAX_COORD)), CW'($urandom_range(MAX_COORD)), $urandom());
  endtask

  // a coordinate within reach of c, reflected back if it would leave the screen
  function automatic logic [CW-1:0] near_coord(input logic [CW-1:0] c, input int reach);
    int off;
    int v;
    off = int'($urandom_range(2 * reach)) - reach;
    v   = int'(c) + off;
    if (v < 0 || v > MAX_COORD) v = int'(c) - off;
    return CW'(v);
  endfunction

  // a start then mostly enough steps to finish the line, sometimes a few
  // too many (empty results) or too few (the next start drops the line)
  task automatic queue_line(input logic [CW-1:0] sx, input logic [CW-1:0] sy,
                            input logic [CW-1:0] ex, input logic [CW-1:0] ey);
    int adx;
    int ady;
    int major;
    int steps;
    adx   = int'(ex) - int'(sx);
    ady   = int'(ey) - int'(sy);
    if (adx < 0) adx = -adx;
    if (ady < 0) ady = -ady;
    major = (adx > ady) ? adx : ady;
    if ($urandom_range(99) < 15) steps = int'($urandom_range(major));
    else                         steps = major + int'($urandom_range(2));
    if (steps > 40) steps = int'($urandom_range(40, 5));
    push_cmd(MODE_START, sx, sy, ex, ey, $urandom());
    repeat (steps) push_random_step();
  endtask

  task automatic queue_random(input int target);
    int            first;
    int            pick;
    int            reach;
    logic [CW-1:0] sx;
    logic [CW-1:0] sy;
    first = pending_cmds.size();
    while (pending_cmds.size() - first < target) begin
      pick  = $urandom_range(99);
      sx    = CW'($urandom_range(MAX_COORD));
      sy    = CW'($urandom_range(MAX_COORD));
      reach = ($urandom_range(3) == 0) ? 40 : 10;
      if (pick < 75) begin
        queue_line(sx, sy, near_coord(sx, reach), near_coord(sy, reach));
      end else if (pick < 85) begin
        // far end points, walked only partway
        queue_line(sx, sy, CW'($urandom_range(MAX_COORD)), CW'($urandom_range(MAX_COORD)));
      end else if (pick < 93) begin
        push_random_step();
      end else begin
        push_cmd(MODE_START, sx, sy, sx, sy, $urandom());
      end
    end
  endtask

  task automatic queue_directed();
    int dxs[8];
    int dys[8];
    dxs = '{6, 3, 6, 3, -6, -3, -6, -3};
    dys = '{3, 6, -3, -6, 3, 6, -3, -6};
    // step with no line right after reset
    push_random_step();
    // coincident end points, then a step that finds no line
    push_cmd(MODE_START, 11'd5, 11'd5, 11'd5, 11'd5, 32'h0000_0000);
    push_random_step();
    // one short line per octant, each start dropping the line before it
    for (int i = 0; i < 8; i++) begin
      push_cmd(MODE_START, 11'd100, 11'd100, CW'(100 + dxs[i]), CW'(100 + dys[i]),
               $urandom());
      push_random_step();
    end
    // decision tie on the first step, line ends on the second
    push_cmd(MODE_START, 11'd10, 11'd10, 11'd12, 11'd11, 32'h5A5A_A5A5);
    push_random_step();
    push_random_step();
    // full-screen diagonals at the coordinate and colour extremes
    push_cmd(MODE_START, 11'd0, 11'd0, CW'(MAX_COORD), CW'(MAX_COORD), 32'hFFFF_FFFF);
    push_random_step();
    push_cmd(MODE_START, CW'(MAX_COORD), 11'd0, 11'd0, CW'(MAX_COORD), 32'h8000_0001);
    push_random_step();
  endtask

  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  // sender pause: nothing queued, nothing on the bus, no pixel outstanding
  task automatic wait_drained();
    while (pending_cmds.size() != 0 || cmd_bus.valid || expected_pixels.size() != 0)
      @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  // command driver: predicts each transfer, then offers the next command
  always @(posedge clk) begin : cmd_driver
    line_cmd_t c;
    if (rst) begin
      cmd_bus.valid   <= 1'b0;
      cmd_bus.mode    <= MODE_START;
      cmd_bus.start_x <= '0;
      cmd_bus.start_y <= '0;
      cmd_bus.end_x   <= '0;
      cmd_bus.end_y   <= '0;
      cmd_bus.colour  <= '0;
      ln_active  = 1'b0;
      ln_oct     = OCT_0;
      org_x      = '0;
      org_y      = '0;
      major_len  = '0;
      minor_len  = '0;
      walk_major = '0;
      walk_minor = '0;
      dec        = '0;
      ln_colour  = '0;
    end else begin
      if (cmd_bus.valid && cmd_bus.ready) begin
        c = '{mode: cmd_bus.mode, sx: cmd_bus.start_x, sy: cmd_bus.start_y,
              ex: cmd_bus.end_x, ey: cmd_bus.end_y, colour: cmd_bus.colour};
        expected_pixels.push_back(rasterize(c));
        if (c.mode == MODE_START) n_starts++;
        else                      n_steps++;
      end
      // the bus is free once the current command has transferred
      if (!cmd_bus.valid || cmd_bus.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          c = pending_cmds.pop_front();
          cmd_bus.valid   <= 1'b1;
          cmd_bus.mode    <= c.mode;
          cmd_bus.start_x <= c.sx;
          cmd_bus.start_y <= c.sy;
          cmd_bus.end_x   <= c.ex;
          cmd_bus.end_y   <= c.ey;
          cmd_bus.colour  <= c.colour;
        end else begin
          cmd_bus.valid <= 1'b0;
        end
      end
    end
  end

  // pixel-side ready: random stalls, plus the long hold-off on request
  always @(posedge clk) begin : pix_ready_gen
    if (rst) begin
      pix_bus.ready <= 1'b0;
      hold_left     <= 0;
    end else if (holds_served != hold_requests) begin
      holds_served  <= holds_served + 1;
      hold_left     <= HOLD_CYCLES;
      pix_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      pix_bus.ready <= 1'b0;
    end else begin
      pix_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // pixel monitor: every transfer is checked against the oldest prediction
  always @(posedge clk) begin : pix_monitor
    pixel_t want;
    if (!rst && pix_bus.valid && pix_bus.ready) begin
      if (expected_pixels.size() == 0) begin
        $error("pixel transfer with no command waiting for it");
        errors++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("valid_res", 32'(want.valid_res), 32'(pix_bus.valid_res));
        check_field("pixel_x", 32'(want.x), 32'(pix_bus.pixel_x));
        check_field("pixel_y", 32'(want.y), 32'(pix_bus.pixel_y));
        check_field("pixel_colour", want.colour, pix_bus.pixel_colour);
        check_field("last", 32'(want.last), 32'(pix_bus.last));
        if (want.valid_res) n_pixels++;
        else                n_empty++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : stimulus
    // known values before the first edge
    cmd_bus.valid   = 1'b0;
    cmd_bus.mode    = MODE_START;
    cmd_bus.start_x = '0;
    cmd_bus.start_y = '0;
    cmd_bus.end_x   = '0;
    cmd_bus.end_y   = '0;
    cmd_bus.colour  = '0;
    pix_bus.ready   = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed corner cases at full rate
    set_idling(0, 0);
    queue_directed();
    wait_drained();

    // full rate with a long pixel-side hold-off so the command side backs up
    queue_random(175);
    hold_requests++;
    wait_drained();

    // sparse commands
    set_idling(70, 0);
    queue_random(175);
    wait_drained();

    // heavy pixel-side stalls
    set_idling(0, 70);
    queue_random(175);
    wait_drained();

    // light idling on both sides
    set_idling(17, 17);
    queue_random(175);
    wait_drained();

    // catch any stray pixel after the last expected one
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("covered %0d line starts and %0d step commands over five idling phases",
             n_starts, n_steps);
    $display("checked %0d drawn pixels and %0d empty step results", n_pixels, n_empty);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
